@@ hw/rtl/osg_pkg.sv @@
`timescale 1ns / 1ps

package osg_pkg;

  // Request codes carried on the func field.
  typedef enum logic [1:0] {
    FUNC_OBSTACLE  = 2'd0,
    FUNC_FRAME_END = 2'd1,
    FUNC_VELOCITY  = 2'd2
  } func_t;

  // Configuration register indexes.
  localparam logic REG_BODY_WIDTH    = 1'b0;
  localparam logic REG_FILTER_ENABLE = 1'b1;

  typedef logic [1:0] grade_t;

  localparam grade_t GRADE_STOP  = 2'd0;
  localparam grade_t GRADE_VSLOW = 2'd1;
  localparam grade_t GRADE_SLOW  = 2'd2;
  localparam grade_t GRADE_FREE  = 2'd3;

  // Frames that must pass after a stop before the histories are cleared.
  localparam logic [4:0] WAIT_LIMIT = 5'd20;
  // Longest averaging window.
  localparam logic [4:0] WIN_MAX = 5'd20;

  localparam int VEL_W = 16;
  localparam int SUM_W = 21;
  localparam int MAG_W = 20;

  // Division by five as a multiplication by ceil(2^23 / 5), exact below 2^22.
  localparam int          DIV5_SHIFT = 23;
  localparam logic [20:0] DIV5_MULT  = 21'd1677722;

  typedef struct packed {
    logic   start;
    logic   clear;
    logic   take;
    logic   enable;
    grade_t grade;
  } flt_ctrl_t;

  typedef struct packed {
    logic                    done;
    logic signed [VEL_W-1:0] left;
    logic signed [VEL_W-1:0] right;
  } flt_stat_t;

  function automatic logic [9:0] coeff_of(grade_t g);
    logic [9:0] c;
    unique case (g)
      GRADE_STOP:  c = 10'd0;
      GRADE_VSLOW: c = 10'd102;
      GRADE_SLOW:  c = 10'd205;
      default:     c = 10'd256;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] win_len(grade_t g);
    logic [4:0] n;
    unique case (g)
      GRADE_STOP:  n = 5'd5;
      GRADE_VSLOW: n = 5'd10;
      GRADE_SLOW:  n = 5'd10;
      default:     n = 5'd20;
    endcase
    return n;
  endfunction

  // Window length is five times two to this power.
  function automatic logic [1:0] win_shift(grade_t g);
    logic [1:0] s;
    unique case (g)
      GRADE_STOP:  s = 2'd0;
      GRADE_VSLOW: s = 2'd1;
      GRADE_SLOW:  s = 2'd1;
      default:     s = 2'd2;
    endcase
    return s;
  endfunction

endpackage

@@ hw/rtl/osg_hist_mem.sv @@
`timescale 1ns / 1ps

module osg_hist_mem import osg_pkg::*; #(
  parameter int HISTORY_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(HISTORY_DEPTH)-1:0] waddr,
  input  logic [2*VEL_W-1:0]               wdata,
  input  logic [$clog2(HISTORY_DEPTH)-1:0] raddr,
  output logic [2*VEL_W-1:0]               rdata
);

  // Left sample in the upper half, right sample in the lower half.
  logic [2*VEL_W-1:0] mem [HISTORY_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/osg_grader.sv @@
`timescale 1ns / 1ps

module osg_grader import osg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [12:0] obstacle_x,
  input  logic signed [12:0] obstacle_y,
  input  logic [9:0]         body_width,
  output logic               grade_valid,
  output grade_t             grade
);

  logic               p0;
  logic               p1;
  logic signed [12:0] x0;
  logic signed [12:0] y0;

  logic               straight;
  logic signed [12:0] x1;
  logic [27:0]        r4;
  logic [21:0]        t0;
  logic [21:0]        t1;
  logic [21:0]        t2;

  logic [12:0] ax;
  logic [12:0] ay;
  logic [10:0] w200;
  logic [10:0] w400;
  logic [10:0] w600;
  logic [25:0] xx;
  logic [25:0] yy;

  always_comb begin
    ax   = x0[12] ? 13'(-x0) : 13'(x0);
    ay   = y0[12] ? 13'(-y0) : 13'(y0);
    w200 = 11'(body_width) + 11'd200;
    w400 = 11'(body_width) + 11'd400;
    w600 = 11'(body_width) + 11'd600;
    xx   = 26'(ax) * 26'(ax);
    yy   = 26'(ay) * 26'(ay);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0          <= 1'b0;
      p1          <= 1'b0;
      grade_valid <= 1'b0;
    end else begin
      p0          <= start;
      p1          <= p0;
      grade_valid <= p1;
    end
    if (start) begin
      x0 <= obstacle_x;
      y0 <= obstacle_y;
    end
    // Four times the squared range, and the squares of the three widened thresholds.
    straight <= {ay, 1'b0} < 14'(w200);
    x1       <= x0;
    r4       <= {xx + yy, 2'b00};
    t0       <= 22'(w200) * 22'(w200);
    t1       <= 22'(w400) * 22'(w400);
    t2       <= 22'(w600) * 22'(w600);
    if (straight) begin
      if (x1 < 13'sd300) begin
        grade <= GRADE_STOP;
      end else if (x1 < 13'sd500) begin
        grade <= GRADE_VSLOW;
      end else if (x1 < 13'sd700) begin
        grade <= GRADE_SLOW;
      end else begin
        grade <= GRADE_FREE;
      end
    end else begin
      if (r4 < 28'(t0)) begin
        grade <= GRADE_STOP;
      end else if (r4 < 28'(t1)) begin
        grade <= GRADE_VSLOW;
      end else if (r4 < 28'(t2)) begin
        grade <= GRADE_SLOW;
      end else begin
        grade <= GRADE_FREE;
      end
    end
  end

endmodule

@@ hw/rtl/osg_filter.sv @@
`timescale 1ns / 1ps

module osg_filter import osg_pkg::*; #(
  parameter int HISTORY_DEPTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  flt_ctrl_t               ctrl,
  input  logic signed [VEL_W-1:0] vel_left,
  input  logic signed [VEL_W-1:0] vel_right,
  output flt_stat_t               stat
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(HISTORY_DEPTH - 1);

  typedef enum logic [6:0] {
    F_IDLE  = 7'b0000001,
    F_SCALE = 7'b0000010,
    F_PUSH  = 7'b0000100,
    F_SUM   = 7'b0001000,
    F_DIV   = 7'b0010000,
    F_FIN   = 7'b0100000,
    F_DONE  = 7'b1000000
  } fstate_t;

  fstate_t fstate;

  logic [AW-1:0] ptr;
  logic [4:0]    fill;
  logic [4:0]    idx;
  logic          pend;
  logic          pend_ok;

  grade_t                  g;
  logic                    en;
  logic signed [VEL_W-1:0] lv;
  logic signed [VEL_W-1:0] rv;
  logic signed [VEL_W-1:0] sl;
  logic signed [VEL_W-1:0] sr;
  logic signed [SUM_W-1:0] acc_l;
  logic signed [SUM_W-1:0] acc_r;
  logic [40:0]             prod_l;
  logic [40:0]             prod_r;
  logic                    neg_l;
  logic                    neg_r;
  logic signed [VEL_W-1:0] res_l;
  logic signed [VEL_W-1:0] res_r;

  logic               mem_we;
  logic [AW-1:0]      raddr;
  logic [2*VEL_W-1:0] rdata;
  logic [AW:0]        ptr_ext;
  logic [AW:0]        idx_ext;
  logic [SUM_W-1:0]   mag_l;
  logic [SUM_W-1:0]   mag_r;
  logic [17:0]        q_l;
  logic [17:0]        q_r;

  // Velocity times a Q8 coefficient, quotient truncated toward zero.
  function automatic logic signed [VEL_W-1:0] scale_vel(logic signed [VEL_W-1:0] v,
                                                        logic [9:0] c);
    logic signed [26:0] p;
    logic signed [26:0] pb;
    p  = 27'(v) * $signed({17'd0, c});
    pb = p + (p[26] ? 27'sd255 : 27'sd0);
    return pb[23:8];
  endfunction

  // Entry idx places before the newest one, wrapping round the buffer.
  always_comb begin
    ptr_ext = {1'b0, ptr};
    idx_ext = (AW + 1)'(idx);
    if (idx_ext > ptr_ext) begin
      raddr = AW'(ptr_ext + DEPTH_W - idx_ext);
    end else begin
      raddr = AW'(ptr_ext - idx_ext);
    end
    mag_l = acc_l[SUM_W-1] ? SUM_W'(-acc_l) : SUM_W'(acc_l);
    mag_r = acc_r[SUM_W-1] ? SUM_W'(-acc_r) : SUM_W'(acc_r);
    q_l   = prod_l[40:DIV5_SHIFT] >> win_shift(g);
    q_r   = prod_r[40:DIV5_SHIFT] >> win_shift(g);
    mem_we = (fstate == F_PUSH);
  end

  osg_hist_mem #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(ptr),
    .wdata({sl, sr}),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
      ptr    <= '0;
      fill   <= '0;
      pend   <= 1'b0;
    end else begin
      unique case (fstate)
        F_IDLE: begin
          if (ctrl.start) begin
            fstate <= F_SCALE;
          end
        end
        F_SCALE: begin
          fstate <= en ? F_PUSH : F_DONE;
        end
        F_PUSH: begin
          fstate <= F_SUM;
          pend   <= 1'b0;
        end
        F_SUM: begin
          pend <= (idx < win_len(g));
          if ((idx == win_len(g)) && !pend) begin
            fstate <= F_DIV;
          end
        end
        F_DIV: begin
          fstate <= F_FIN;
        end
        F_FIN: begin
          fstate <= F_DONE;
          ptr    <= (ptr == LAST) ? '0 : ptr + 1'b1;
          fill   <= (fill == WIN_MAX) ? WIN_MAX : fill + 1'b1;
        end
        F_DONE: begin
          if (ctrl.take) begin
            fstate <= F_IDLE;
          end
        end
        default: begin
          fstate <= F_IDLE;
        end
      endcase
      if (ctrl.clear) begin
        fill <= '0;
      end
    end

    if (fstate == F_IDLE && ctrl.start) begin
      lv <= vel_left;
      rv <= vel_right;
      g  <= ctrl.grade;
      en <= ctrl.enable;
    end
    if (fstate == F_SCALE) begin
      sl    <= scale_vel(lv, coeff_of(g));
      sr    <= scale_vel(rv, coeff_of(g));
      res_l <= scale_vel(lv, coeff_of(g));
      res_r <= scale_vel(rv, coeff_of(g));
    end
    if (fstate == F_PUSH) begin
      acc_l <= SUM_W'(sl);
      acc_r <= SUM_W'(sr);
      idx   <= 5'd1;
    end
    if (fstate == F_SUM) begin
      if (idx < win_len(g)) begin
        idx     <= idx + 1'b1;
        pend_ok <= (idx <= fill);
      end
      if (pend && pend_ok) begin
        acc_l <= acc_l + SUM_W'($signed(rdata[2*VEL_W-1:VEL_W]));
        acc_r <= acc_r + SUM_W'($signed(rdata[VEL_W-1:0]));
      end
    end
    if (fstate == F_DIV) begin
      prod_l <= 41'(mag_l[MAG_W-1:0]) * 41'(DIV5_MULT);
      prod_r <= 41'(mag_r[MAG_W-1:0]) * 41'(DIV5_MULT);
      neg_l  <= acc_l[SUM_W-1];
      neg_r  <= acc_r[SUM_W-1];
    end
    if (fstate == F_FIN) begin
      res_l <= neg_l ? VEL_W'(-q_l) : VEL_W'(q_l);
      res_r <= neg_r ? VEL_W'(-q_r) : VEL_W'(q_r);
    end
  end

  assign stat.done  = (fstate == F_DONE);
  assign stat.left  = res_l;
  assign stat.right = res_r;

endmodule

@@ hw/rtl/obstacle_speed_governor_filter_unit.sv @@
`timescale 1ns / 1ps
// An obstacle request passes through the grader's registers; a frame-end request is
// settled in the idle state. A velocity request is scaled, pushed, summed over the
// window and divided, or only scaled with filtering off.
// Throughput: one request at a time; the history sum reads one memory entry a cycle.
// Reset (rst, synchronous) restores the control registers, grade 3 and an empty history.

module obstacle_speed_governor_filter_unit import osg_pkg::*; #(
  parameter int HISTORY_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  // Request channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic signed [12:0] obstacle_x,
  input  logic signed [12:0] obstacle_y,
  input  logic signed [15:0] vel_left,
  input  logic signed [15:0] vel_right,
  // Result channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] left_out,
  output logic signed [15:0] right_out,
  output logic [1:0]         speed_level,
  output logic               waiting,
  // Configuration port.
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [9:0]         cfg_data
);

  // The top level only sequences requests: obstacles go to the grader, velocity
  // samples to the filter, and frame ends are settled here.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_GRADE = 3'b010,
    ST_FILT  = 3'b100
  } state_t;

  state_t state;

  logic [9:0] body_width;
  logic       filter_enable;
  grade_t     speed_grade;
  grade_t     frame_best;
  logic       wait_active;
  logic [4:0] wait_count;
  grade_t     sample_level;
  logic       sample_wait;

  logic      accept;
  logic      grade_valid;
  grade_t    obstacle_grade;
  flt_ctrl_t flt_ctrl;
  flt_stat_t flt_stat;
  logic      take;

  grade_t     speed_grade_next;
  logic       wait_active_next;
  logic [4:0] wait_count_next;
  logic       hist_clear;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  // The finished sample moves to the output register once that register is free.
  assign take     = (state == ST_FILT) && flt_stat.done && (!out_valid || out_ready);

  // Frame end: the least grade of the frame becomes the speed grade. A stop grade
  // starts the wait, which holds the grade at stop and counts frames; once the
  // count passes its limit the wait ends and both histories are emptied.
  always_comb begin
    speed_grade_next = frame_best;
    wait_active_next = wait_active;
    wait_count_next  = wait_count;
    hist_clear       = 1'b0;
    if (frame_best == GRADE_STOP) begin
      wait_active_next = 1'b1;
      wait_count_next  = '0;
    end
    if (wait_active_next) begin
      wait_count_next  = wait_count_next + 1'b1;
      speed_grade_next = GRADE_STOP;
    end
    if (wait_count_next > WAIT_LIMIT) begin
      hist_clear       = 1'b1;
      wait_active_next = 1'b0;
      wait_count_next  = '0;
    end
  end

  always_comb begin
    flt_ctrl.start  = accept && (func == FUNC_VELOCITY);
    flt_ctrl.clear  = accept && (func == FUNC_FRAME_END) && hist_clear;
    flt_ctrl.take   = take;
    flt_ctrl.enable = filter_enable;
    flt_ctrl.grade  = speed_grade;
  end

  osg_grader u_grader (
    .clk        (clk),
    .rst        (rst),
    .start      (accept && (func == FUNC_OBSTACLE)),
    .obstacle_x (obstacle_x),
    .obstacle_y (obstacle_y),
    .body_width (body_width),
    .grade_valid(grade_valid),
    .grade      (obstacle_grade)
  );

  osg_filter #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_filter (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (flt_ctrl),
    .vel_left (vel_left),
    .vel_right(vel_right),
    .stat     (flt_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      body_width    <= 10'd100;
      filter_enable <= 1'b1;
      speed_grade   <= GRADE_FREE;
      frame_best    <= GRADE_FREE;
      wait_active   <= 1'b0;
      wait_count    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_BODY_WIDTH:    body_width    <= cfg_data;
          REG_FILTER_ENABLE: filter_enable <= cfg_data[0];
          default:           body_width    <= body_width;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (func)
              FUNC_OBSTACLE: begin
                state <= ST_GRADE;
              end
              FUNC_FRAME_END: begin
                frame_best  <= GRADE_FREE;
                speed_grade <= speed_grade_next;
                wait_active <= wait_active_next;
                wait_count  <= wait_count_next;
              end
              FUNC_VELOCITY: begin
                state <= ST_FILT;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_GRADE: begin
          if (grade_valid) begin
            state <= ST_IDLE;
            if (obstacle_grade < frame_best) begin
              frame_best <= obstacle_grade;
            end
          end
        end
        ST_FILT: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end

    // The grade and wait flag seen by a sample are those in force when it arrives.
    if (accept && (func == FUNC_VELOCITY)) begin
      sample_level <= speed_grade;
      sample_wait  <= wait_active;
    end
    if (take) begin
      left_out    <= flt_stat.left;
      right_out   <= flt_stat.right;
      speed_level <= sample_level;
      waiting     <= sample_wait;
    end
  end

  // The stop wait always forces the stop grade.
  a_wait_forces_stop: assert property (@(posedge clk) disable iff (rst)
    wait_active |-> speed_grade == GRADE_STOP)
    else $error("wait in force without stop grade");

  // The frame counter only runs while the wait is in force.
  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !wait_active |-> wait_count == '0)
    else $error("wait count running outside a wait");

  // A grade arrives from the grader only while an obstacle request is pending.
  a_grade_expected: assert property (@(posedge clk) disable iff (rst)
    grade_valid |-> state == ST_GRADE)
    else $error("unexpected obstacle grade");

  // The filter finishes only while a velocity request is pending.
  a_filter_expected: assert property (@(posedge clk) disable iff (rst)
    flt_stat.done |-> state == ST_FILT)
    else $error("unexpected filter result");

endmodule
